// ===== rtl/core/lfse_pkg.sv =====
package lfse_pkg;

    // frame geometry
    localparam int FrameBytes   = 56;
    localparam int WordsPerPass = FrameBytes / 2;
    localparam int FrameBits    = WordsPerPass * 4;
    localparam int WordIdxW     = $clog2(WordsPerPass);
    localparam logic [WordIdxW-1:0] LastWordIdx = WordIdxW'(WordsPerPass - 1);

    // line symbols for one frame bit
    localparam logic [3:0] SymZero = 4'h8;
    localparam logic [3:0] SymOne  = 4'hE;

    // configuration register indexes
    localparam logic [2:0] CfgGainRed    = 3'd0;
    localparam logic [2:0] CfgGainGreen  = 3'd1;
    localparam logic [2:0] CfgGainBlue   = 3'd2;
    localparam logic [2:0] CfgGainWhite  = 3'd3;
    localparam logic [2:0] CfgGainYellow = 3'd4;
    localparam logic [2:0] CfgReserve    = 3'd5;
    localparam logic [2:0] CfgSleepCode  = 3'd6;

    localparam logic [4:0] ReserveReset = 5'h1F;

    // one queued frame: raw bits plus the wake repeat flag
    typedef struct packed {
        logic [FrameBits-1:0] frame;
        logic                 two_pass;
    } t_job;

    // four frame bits to four line symbols, MSB first
    function automatic logic [15:0] sym_word(input logic [3:0] bits);
        logic [15:0] w;
        for (int i = 0; i < 4; i++) begin
            w[i*4 +: 4] = bits[i] ? SymOne : SymZero;
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/lfse_pix_if.sv =====
interface lfse_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;
    logic [15:0] white_level;
    logic [15:0] yellow_level;
    logic [1:0]  standby_mode;

    modport source (
        output valid, red_level, green_level, blue_level, white_level,
               yellow_level, standby_mode,
        input  ready
    );
    modport sink (
        input  valid, red_level, green_level, blue_level, white_level,
               yellow_level, standby_mode,
        output ready
    );
endinterface

// ===== rtl/core/lfse_sym_if.sv =====
interface lfse_sym_if;
    logic        valid;
    logic        ready;
    logic [15:0] symbol_word;
    logic        pass_number;
    logic        last_word;

    modport source (
        output valid, symbol_word, pass_number, last_word,
        input  ready
    );
    modport sink (
        input  valid, symbol_word, pass_number, last_word,
        output ready
    );
endinterface

// ===== rtl/core/lfse_front.sv =====
module lfse_front
    import lfse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    lfse_pix_if.sink    i_pix,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [4:0] r_gain_red, r_gain_green, r_gain_blue, r_gain_white, r_gain_yellow;
    logic [4:0] r_reserve;
    logic [1:0] r_sleep;
    logic [1:0] r_prev_sb;
    logic       r_seen;
    logic       w_acc;
    logic       w_change;

    assign i_pix.ready = !i_full;
    assign w_acc       = i_pix.valid && !i_full;
    assign w_change    = !r_seen || (r_prev_sb != i_pix.standby_mode);

    // frame assembly and wake classification
    assign o_push         = w_acc;
    assign o_job.frame    = {i_pix.red_level, i_pix.green_level, i_pix.blue_level,
                             i_pix.white_level, i_pix.yellow_level,
                             r_gain_red, r_gain_green, r_gain_blue, r_gain_white,
                             r_gain_yellow, i_pix.standby_mode, r_reserve};
    assign o_job.two_pass = r_seen && (r_prev_sb == r_sleep)
                            && (r_prev_sb != i_pix.standby_mode);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_red    <= '0;
            r_gain_green  <= '0;
            r_gain_blue   <= '0;
            r_gain_white  <= '0;
            r_gain_yellow <= '0;
            r_reserve     <= ReserveReset;
            r_sleep       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgGainRed:    r_gain_red    <= i_cfg_data;
                CfgGainGreen:  r_gain_green  <= i_cfg_data;
                CfgGainBlue:   r_gain_blue   <= i_cfg_data;
                CfgGainWhite:  r_gain_white  <= i_cfg_data;
                CfgGainYellow: r_gain_yellow <= i_cfg_data;
                CfgReserve:    r_reserve     <= i_cfg_data;
                CfgSleepCode:  r_sleep       <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // standby history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sb <= '0;
            r_seen    <= 1'b0;
        end else if (w_acc && w_change) begin
            r_prev_sb <= i_pix.standby_mode;
            r_seen    <= 1'b1;
        end
    end

    // wake repeat only when the standby actually moves
    a_two_needs_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && o_job.two_pass) |-> w_change)
        else $error("wake repeat without standby change");
    a_seen_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_acc) && i_rst_n && $past(i_rst_n) |-> r_seen)
        else $error("standby history not set after a word");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("push into full queue");

endmodule

// ===== rtl/core/lfse_fifo.sv =====
module lfse_fifo
    import lfse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;
    logic       w_wr, w_rd;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_count <= r_count + 2'(w_wr) - 2'(w_rd);
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/lfse_back.sv =====
module lfse_back
    import lfse_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_job_valid,
    input  t_job         i_job,
    output logic         o_pop,
    lfse_sym_if.source   o_sym
);

    logic [WordIdxW-1:0]  r_k;
    logic                 r_pass;
    logic                 r_valid;
    logic [15:0]          r_word;
    logic                 r_pass_out;
    logic                 r_last;
    logic                 w_adv;
    logic                 w_end_pass;
    logic                 w_last;
    logic [WordIdxW-1:0]  w_idx;
    logic [3:0]           w_bits;

    assign o_sym.valid       = r_valid;
    assign o_sym.symbol_word = r_word;
    assign o_sym.pass_number = r_pass_out;
    assign o_sym.last_word   = r_last;

    // next word of the current frame, MSB first
    assign w_adv      = i_job_valid && (!r_valid || o_sym.ready);
    assign w_end_pass = (r_k == LastWordIdx);
    assign w_last     = w_end_pass && (r_pass || !i_job.two_pass);
    assign w_idx      = LastWordIdx - r_k;
    assign w_bits     = i_job.frame[{w_idx, 2'b00} +: 4];
    assign o_pop      = w_adv && w_last;

    // word counter, pass counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_pass  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_valid <= 1'b1;
                if (w_end_pass) begin
                    r_k    <= '0;
                    r_pass <= !w_last;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end else if (o_sym.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_word     <= sym_word(w_bits);
            r_pass_out <= r_pass;
            r_last     <= w_last;
        end
    end

    a_repeat_holds_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass |-> (i_job_valid && i_job.two_pass))
        else $error("repeat pass without a wake frame");
    a_mid_frame_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != '0) |-> i_job_valid)
        else $error("frame lost mid pass");
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_end_pass) |=> !r_last)
        else $error("last word flagged inside a pass");

endmodule

// ===== rtl/core/led_frame_symbol_encoder.sv =====
// LED frame symbol encoder.
// i_pix carries one pixel word: five 16-bit gray levels and a 2-bit standby
// mode, taken when valid and ready are both high. o_sym gives 16-bit symbol
// words (four frame bits, 0x8 for zero and 0xE for one, MSB first), with the
// pass number and a flag on the last word of the run.
// Gains, reserve bits and the sleep code are written over the i_cfg_* port
// while the block is idle; the user keeps to this, the block does not enforce
// it. Index 0..6, other indexes are ignored. With the serializer idle, each
// taken pixel is queued, then its first symbol word is registered for output.
// Throughput: one symbol word per cycle from the output register while the
// receiver is ready and a frame is queued, 28 words per pixel, or 56 when the
// standby leaves the sleep code (the frame is repeated with pass number 1). A
// two-entry frame queue sits between the pixel side and the serializer; the
// frame going out holds one entry, so one more pixel is taken as it goes out.
// Reset (synchronous, active low) empties the queue, clears the standby
// history and sets gains to 0, reserve bits to 31 and the sleep code to 0.
// When the receiver drops ready, the current word holds; the queue then fills
// and i_pix.ready falls until words move again.
module led_frame_symbol_encoder
    import lfse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    lfse_pix_if.sink    i_pix,
    lfse_sym_if.source  o_sym
);

    logic w_push, w_full, w_pop, w_job_valid;
    t_job w_in_job, w_out_job;

    lfse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_in_job)
    );

    lfse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_job   (w_out_job)
    );

    lfse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_out_job),
        .o_pop       (w_pop),
        .o_sym       (o_sym)
    );

endmodule

// ===== tb/led_frame_symbol_encoder_test.sv =====
`timescale 1ns / 1ps

module led_frame_symbol_encoder_test;
    import lfse_pkg::*;

    localparam logic [2:0] CfgUnused = 3'd7;   // no register here, writes dropped
    localparam int CycleLimit    = 3_000_000;
    localparam int RandomPhases  = 7;
    localparam int ItemsPerPhase = 40;
    localparam int SettleCycles  = 8;

    // one expected symbol word
    typedef struct packed {
        logic [15:0] symbol_word;
        logic        pass_number;
        logic        last_word;
    } t_sym_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [4:0] i_cfg_data;

    lfse_pix_if pix ();
    lfse_sym_if sym ();

    led_frame_symbol_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix),
        .o_sym       (sym)
    );

    // shadow registers and standby history
    logic [4:0] gain_r, gain_g, gain_b, gain_w, gain_y;
    logic [4:0] reserve;
    logic [1:0] sleep_mode;
    logic [1:0] last_standby;
    logic       standby_valid;

    t_sym_word symbol_expect_q[$];
    int        pix_taken  = 0;
    int        fail_cnt   = 0;
    int        cycle_cnt  = 0;
    int        stall_left = 0;
    bit        quiet;           // no gaps and no stalls while set

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // frame -> symbol words; applies the standby history the way the block does
    function automatic void queue_frame_symbols(input logic [15:0] r, g, b, wh, y,
                                                input logic [1:0] sb);
        logic [31:0]          tail;
        logic [FrameBits-1:0] frame_bits;
        logic [3:0]           nib;
        int                   passes;
        t_sym_word            w;
        tail       = {gain_r, gain_g, gain_b, gain_w, gain_y, sb, reserve};
        frame_bits = {r, g, b, wh, y, tail};
        passes     = 1;
        if (!standby_valid || last_standby != sb) begin
            // leaving sleep repeats the frame
            if (standby_valid && last_standby == sleep_mode) passes = 2;
            last_standby  = sb;
            standby_valid = 1'b1;
        end
        for (int p = 0; p < passes; p++) begin
            for (int k = 0; k < WordsPerPass; k++) begin
                nib = frame_bits[FrameBits-1-4*k -: 4];
                for (int i = 0; i < 4; i++) begin
                    w.symbol_word[15-4*i -: 4] = nib[3-i] ? SymOne : SymZero;
                end
                w.pass_number = p[0];
                w.last_word   = (p == passes - 1) && (k == WordsPerPass - 1);
                symbol_expect_q.push_back(w);
            end
        end
    endfunction

    // pixel side: predict on every accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && pix.valid && pix.ready) begin
            queue_frame_symbols(pix.red_level, pix.green_level, pix.blue_level,
                                pix.white_level, pix.yellow_level, pix.standby_mode);
            pix_taken++;
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        fail_cnt++;
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_cnt, what, got, want);
    endtask

    // symbol side: compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin : sym_check
        t_sym_word want;
        if (i_rst_n && sym.valid && sym.ready) begin
            if (symbol_expect_q.size() == 0) begin
                report_mismatch("symbol word with none expected", sym.symbol_word, 16'h0);
            end else begin
                want = symbol_expect_q.pop_front();
                if (sym.symbol_word !== want.symbol_word)
                    report_mismatch("symbol_word", sym.symbol_word, want.symbol_word);
                if (sym.pass_number !== want.pass_number)
                    report_mismatch("pass_number", 16'(sym.pass_number),
                                    16'(want.pass_number));
                if (sym.last_word !== want.last_word)
                    report_mismatch("last_word", 16'(sym.last_word), 16'(want.last_word));
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            sym.ready <= 1'b0;
        end else begin
            sym.ready <= 1'b1;
            stall_left = idle_len();
        end
    end

    // one pixel word; entered and left at a falling edge
    task automatic send_pixel(input logic [15:0] r, g, b, wh, y, input logic [1:0] sb);
        int gap;
        int seen;
        gap = idle_len();
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix.valid        <= 1'b1;
        pix.red_level    <= r;
        pix.green_level  <= g;
        pix.blue_level   <= b;
        pix.white_level  <= wh;
        pix.yellow_level <= y;
        pix.standby_mode <= sb;
        seen = pix_taken;
        do @(negedge i_clk); while (pix_taken == seen);
    endtask

    task automatic send_flat(input logic [15:0] lvl, input logic [1:0] sb);
        send_pixel(lvl, lvl, lvl, lvl, lvl, sb);
    endtask

    // wait until every expected word is out and the block is quiet
    task automatic settle();
        pix.valid <= 1'b0;
        while (symbol_expect_q.size() > 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // register write; only while idle
    task automatic write_reg(input logic [2:0] idx, input logic [4:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CfgGainRed:    gain_r     = data;
            CfgGainGreen:  gain_g     = data;
            CfgGainBlue:   gain_b     = data;
            CfgGainWhite:  gain_w     = data;
            CfgGainYellow: gain_y     = data;
            CfgReserve:    reserve    = data;
            CfgSleepCode:  sleep_mode = data[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_all(input logic [4:0] gain, input logic [4:0] rsv,
                             input logic [4:0] sleep);
        write_reg(CfgGainRed, gain);
        write_reg(CfgGainGreen, gain);
        write_reg(CfgGainBlue, gain);
        write_reg(CfgGainWhite, gain);
        write_reg(CfgGainYellow, gain);
        write_reg(CfgReserve, rsv);
        write_reg(CfgSleepCode, sleep);
    endtask

    // reset values: first frame, unchanged standby, wake from sleep code 0
    task automatic test_history_after_reset();
        send_flat(16'h0000, 2'd0);
        send_flat(16'hFFFF, 2'd0);
        send_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F, 2'd1);
        send_flat(16'h8001, 2'd1);
        send_flat(16'h7FFE, 2'd2);
        send_flat(16'hC3C3, 2'd0);
    endtask

    // level extremes and bit patterns, standby held
    task automatic test_level_extremes();
        send_flat(16'h0000, 2'd0);
        send_flat(16'hFFFF, 2'd0);
        send_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 2'd0);
        send_pixel(16'h8000, 16'h0001, 16'h0100, 16'h0080, 16'h4002, 2'd0);
    endtask

    // register extremes, masked sleep code and the unused index
    task automatic test_register_extremes();
        settle();
        write_all(5'h1F, 5'h00, 5'b11110);
        write_reg(CfgUnused, 5'h1F);
        send_flat(16'h0F0F, 2'd2);
        send_flat(16'hF0F0, 2'd3);
        settle();
        write_all(5'h00, ReserveReset, 5'h03);
        send_flat(16'h3C3C, 2'd3);
        send_flat(16'hC3C3, 2'd1);
    endtask

    // enter sleep and wake into the next value for every sleep code
    task automatic test_wake_paths();
        for (int s = 0; s < 4; s++) begin
            settle();
            write_reg(CfgSleepCode, 5'(s));
            send_flat(16'($urandom), 2'(s));
            send_flat(16'($urandom), 2'(s + 1));
        end
    endtask

    function automatic logic [15:0] rand_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // random frames over several settings; standby walks in and out of sleep
    task automatic test_random_frames();
        logic [1:0] sb;
        int         r;
        for (int ph = 0; ph < RandomPhases; ph++) begin
            settle();
            quiet = (ph == 2 || ph == 5);
            if (ph == 0) begin
                write_all(5'h1F, 5'h1F, 5'h1F);
            end else if (ph == 1) begin
                write_all(5'h00, 5'h00, 5'h00);
            end else begin
                write_reg(CfgGainRed, 5'($urandom));
                write_reg(CfgGainGreen, 5'($urandom));
                write_reg(CfgGainBlue, 5'($urandom));
                write_reg(CfgGainWhite, 5'($urandom));
                write_reg(CfgGainYellow, 5'($urandom));
                write_reg(CfgReserve, 5'($urandom));
                write_reg(CfgSleepCode, 5'($urandom));
                if ($urandom_range(0, 1)) write_reg(CfgUnused, 5'($urandom));
            end
            sb = last_standby;
            for (int n = 0; n < ItemsPerPhase; n++) begin
                r = $urandom_range(0, 99);
                if (r >= 45 && r < 75) sb = sleep_mode;
                else if (r >= 75) sb = 2'($urandom);
                send_pixel(rand_level(), rand_level(), rand_level(), rand_level(),
                           rand_level(), sb);
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        pix.valid        = 1'b0;
        pix.red_level    = '0;
        pix.green_level  = '0;
        pix.blue_level   = '0;
        pix.white_level  = '0;
        pix.yellow_level = '0;
        pix.standby_mode = '0;
        sym.ready        = 1'b0;
        quiet            = 1'b0;
        gain_r           = '0;
        gain_g           = '0;
        gain_b           = '0;
        gain_w           = '0;
        gain_y           = '0;
        reserve          = ReserveReset;
        sleep_mode       = '0;
        last_standby     = '0;
        standby_valid    = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_history_after_reset();
        test_level_extremes();
        test_register_extremes();
        test_wake_paths();
        test_random_frames();
        settle();

        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
